// File: rtl/sensor_frame_crc_check_convert_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_UNIT_MACROS_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SFCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SFCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sfcc_pkg.sv
package sfcc_pkg;

    localparam int WORD_W  = 16;
    localparam int CHK_W   = 8;
    localparam int TEMP_W  = 15;
    localparam int HUM_W   = 14;

    localparam logic [CHK_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [CHK_W-1:0] CRC_POLY = 8'h31;

    localparam logic [14:0] T_SCALE    = 15'd17500;
    localparam logic [13:0] H_SCALE    = 14'd10000;
    localparam logic [15:0] T_OFFSET   = 16'd4500;
    localparam logic [HUM_W-1:0] H_MAX = 14'd10000;
    localparam logic [15:0] ROUND_HALF = 16'h8000;

    localparam int T_PROD_W = 31;
    localparam int H_PROD_W = 30;

    localparam logic FRAME_OK      = 1'b0;
    localparam logic FRAME_CRC_ERR = 1'b1;

    // Per-lane result handed to the merge stage.
    typedef struct packed {
        logic match;
    } t_lane_res;

    // One byte through the MSB-first CRC-8, eight shift steps.
    function automatic logic [CHK_W-1:0] crc_byte(input logic [CHK_W-1:0] crc_in,
                                                  input logic [CHK_W-1:0] data);
        logic [CHK_W-1:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[CHK_W-1]) begin
                c = {c[CHK_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CHK_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: rtl/sensor_frame_crc_check_convert_unit.sv
// Sensor frame check and conversion.
// Input channel: i_valid / o_stall carry one frame per transaction: three raw
// words (CO2, temperature, humidity), each with its received CRC-8 byte.
// Output channel: o_valid / i_stall carry one result per frame: CO2 in ppm,
// temperature and humidity in hundredths, and a status bit that is set when
// any CRC mismatches (all values then read zero).
// Two register stages: an accepted frame sits in the lane registers and r_v1,
// then in the output register. One frame per cycle while unstalled: three CRC
// lanes and one conversion lane run side by side, each split over two
// register stages (high byte and constant multiplies first, low byte,
// rounding and clamping second), and the merge into the output register
// combines the lane checks.
// While the receiver stalls a valid result, the whole pipe holds and o_stall
// is raised to the sender; a bubble in the output register is always filled.
// Reset empties the pipe; no frame is lost or repeated across a stall.
module sensor_frame_crc_check_convert_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [sfcc_pkg::WORD_W-1:0]        i_co2_word,
    input  logic [sfcc_pkg::CHK_W-1:0]         i_co2_check,
    input  logic [sfcc_pkg::WORD_W-1:0]        i_temp_word,
    input  logic [sfcc_pkg::CHK_W-1:0]         i_temp_check,
    input  logic [sfcc_pkg::WORD_W-1:0]        i_hum_word,
    input  logic [sfcc_pkg::CHK_W-1:0]         i_hum_check,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sfcc_pkg::WORD_W-1:0]        o_co2_ppm,
    output logic signed [sfcc_pkg::TEMP_W-1:0] o_temp_centi,
    output logic [sfcc_pkg::HUM_W-1:0]         o_hum_centi,
    output logic                               o_frame_status
);
    import sfcc_pkg::*;

    logic r_v1, n_v1;
    logic r_v2, n_v2;
    logic adv;

    t_lane_res res_co2, res_temp, res_hum;
    logic [WORD_W-1:0]        conv_co2;
    logic signed [TEMP_W-1:0] conv_temp;
    logic [HUM_W-1:0]         conv_hum;
    logic                     all_good;

    logic [WORD_W-1:0]        r_co2, n_co2;
    logic signed [TEMP_W-1:0] r_temp, n_temp;
    logic [HUM_W-1:0]         r_hum, n_hum;
    logic                     r_status, n_status;

    assign adv     = !r_v2 || !i_stall;
    assign o_stall = !adv;

    sfcc_crc_lane u_lane_co2 (
        .i_clk(i_clk), .i_en(adv), .i_word(i_co2_word), .i_check(i_co2_check),
        .o_res(res_co2)
    );
    sfcc_crc_lane u_lane_temp (
        .i_clk(i_clk), .i_en(adv), .i_word(i_temp_word), .i_check(i_temp_check),
        .o_res(res_temp)
    );
    sfcc_crc_lane u_lane_hum (
        .i_clk(i_clk), .i_en(adv), .i_word(i_hum_word), .i_check(i_hum_check),
        .o_res(res_hum)
    );

    sfcc_conv_lane u_conv (
        .i_clk(i_clk), .i_en(adv),
        .i_co2_word(i_co2_word), .i_temp_word(i_temp_word), .i_hum_word(i_hum_word),
        .o_co2(conv_co2), .o_temp(conv_temp), .o_hum(conv_hum)
    );

    assign all_good = res_co2.match && res_temp.match && res_hum.match;

    always_comb begin
        n_v1     = r_v1;
        n_v2     = r_v2;
        n_co2    = r_co2;
        n_temp   = r_temp;
        n_hum    = r_hum;
        n_status = r_status;
        if (adv) begin
            n_v1 = i_valid;
            n_v2 = r_v1;
            if (all_good) begin
                n_co2    = conv_co2;
                n_temp   = conv_temp;
                n_hum    = conv_hum;
                n_status = FRAME_OK;
            end else begin
                n_co2    = '0;
                n_temp   = '0;
                n_hum    = '0;
                n_status = FRAME_CRC_ERR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_co2    <= n_co2;
        r_temp   <= n_temp;
        r_hum    <= n_hum;
        r_status <= n_status;
    end

    assign o_valid        = r_v2;
    assign o_co2_ppm      = r_co2;
    assign o_temp_centi   = r_temp;
    assign o_hum_centi    = r_hum;
    assign o_frame_status = r_status;

endmodule

// File: rtl/sfcc_crc_lane.sv
module sfcc_crc_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [sfcc_pkg::WORD_W-1:0] i_word,
    input  logic [sfcc_pkg::CHK_W-1:0]  i_check,
    output sfcc_pkg::t_lane_res       o_res
);
    import sfcc_pkg::*;

    logic [CHK_W-1:0] r_crc_hi;
    logic [CHK_W-1:0] r_lo;
    logic [CHK_W-1:0] r_check;
    logic [CHK_W-1:0] crc_full;

    // High byte folded in the first stage, low byte in the second.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_crc_hi <= crc_byte(CRC_INIT, i_word[WORD_W-1:CHK_W]);
            r_lo     <= i_word[CHK_W-1:0];
            r_check  <= i_check;
        end
    end

    assign crc_full    = crc_byte(r_crc_hi, r_lo);
    assign o_res.match = (crc_full == r_check);

endmodule

// File: rtl/sfcc_conv_lane.sv
module sfcc_conv_lane (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [sfcc_pkg::WORD_W-1:0]        i_co2_word,
    input  logic [sfcc_pkg::WORD_W-1:0]        i_temp_word,
    input  logic [sfcc_pkg::WORD_W-1:0]        i_hum_word,
    output logic [sfcc_pkg::WORD_W-1:0]        o_co2,
    output logic signed [sfcc_pkg::TEMP_W-1:0] o_temp,
    output logic [sfcc_pkg::HUM_W-1:0]         o_hum
);
    import sfcc_pkg::*;

    logic [WORD_W-1:0]   r_co2;
    logic [T_PROD_W-1:0] r_t_prod;
    logic [H_PROD_W-1:0] r_h_prod;

    logic [T_PROD_W:0]   t_sum;
    logic [H_PROD_W:0]   h_sum;
    logic [15:0]         t_q;
    logic [15:0]         t_diff;
    logic [HUM_W:0]      h_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_co2    <= i_co2_word;
            r_t_prod <= T_PROD_W'(T_SCALE) * T_PROD_W'(i_temp_word);
            r_h_prod <= H_PROD_W'(H_SCALE) * H_PROD_W'(i_hum_word);
        end
    end

    always_comb begin
        t_sum  = {1'b0, r_t_prod} + (T_PROD_W + 1)'(ROUND_HALF);
        h_sum  = {1'b0, r_h_prod} + (H_PROD_W + 1)'(ROUND_HALF);
        t_q    = t_sum[T_PROD_W:16];
        h_q    = h_sum[H_PROD_W:16];
        // wraps to two's complement below the zero point
        t_diff = t_q - T_OFFSET;
        o_temp = signed'(t_diff[TEMP_W-1:0]);
        if (h_q > {1'b0, H_MAX}) begin
            o_hum = H_MAX;
        end else begin
            o_hum = h_q[HUM_W-1:0];
        end
        o_co2 = r_co2;
    end

endmodule

// File: rtl/sfcc_checker.sv
`include "sensor_frame_crc_check_convert_unit_macros.svh"

module sfcc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic [sfcc_pkg::WORD_W-1:0]        o_co2_ppm,
    input  logic signed [sfcc_pkg::TEMP_W-1:0] o_temp_centi,
    input  logic [sfcc_pkg::HUM_W-1:0]         o_hum_centi,
    input  logic                               o_frame_status
);
    import sfcc_pkg::*;

    // a stalled result transaction holds
    `SFCC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_co2_ppm) && $stable(o_temp_centi) && $stable(o_hum_centi) && $stable(o_frame_status), "stalled result changed")

    // back pressure only when a full output register is stalled
    `SFCC_ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, o_stall, o_valid && i_stall, "input stalled without output back pressure")

    `SFCC_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_valid && (o_frame_status == FRAME_CRC_ERR), (o_co2_ppm == '0) && (o_temp_centi == '0) && (o_hum_centi == '0), "CRC error with nonzero values")

    `SFCC_ASSERT_IMPL(a_hum_range, i_clk, i_rst_n, o_valid && (o_frame_status == FRAME_OK), o_hum_centi <= H_MAX, "humidity above full scale")

    `SFCC_ASSERT_IMPL(a_temp_range, i_clk, i_rst_n, o_valid && (o_frame_status == FRAME_OK), (o_temp_centi >= -15'sd4500) && (o_temp_centi <= 15'sd13000), "temperature out of range")

endmodule

bind sensor_frame_crc_check_convert_unit sfcc_checker u_sfcc_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .o_stall(o_stall),
    .o_valid(o_valid),
    .i_stall(i_stall),
    .o_co2_ppm(o_co2_ppm),
    .o_temp_centi(o_temp_centi),
    .o_hum_centi(o_hum_centi),
    .o_frame_status(o_frame_status)
);
